### rtl/mnpa_pkg.sv
// Shared types and constants for the mono note priority assigner.
package mnpa_pkg;

    // Field widths.
    localparam int unsigned KEY_W = 7;
    localparam int unsigned VEL_W = 7;
    localparam int unsigned CMD_W = 2;
    localparam int unsigned MODE_W = 2;

    // Voice commands.
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RETARGET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;

    // Priority modes; the unused code behaves as last-pressed.
    localparam logic [MODE_W-1:0] MODE_LAST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOWEST = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HIGHEST = 2'd2;

    // Event opcodes.
    localparam logic OP_RELEASE = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    typedef logic [KEY_W-1:0] t_key;

    // Token that walks down the cell row, one cell per cycle.
    typedef struct packed {
        logic             active;
        logic             op;
        t_key             key;
        logic [VEL_W-1:0] vel;
        logic             found;
        logic             appended;
        logic             have_best;
        t_key             best;
        logic             have_last;
        t_key             last;
    } t_link;

endpackage

### rtl/mono_note_priority_assigner.sv
// An event passes the entry token register, each cell register and the finished-token register to the output.
// Events are taken one at a time; the token walks one cell per cycle,
// and a stalled output register holds the next event back until its result moves on.
// A new event is taken while the previous result still waits on the output.
// Reset (synchronous, active low) empties the held list and sets mode to last.
// Key storage has no reset; only slots below the held count are ever read.
module mono_note_priority_assigner #(
    parameter int unsigned MAX_KEYS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: priority mode.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    // Event input.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [6:0] key, [13:7] velocity, [15:14] zero
    input  logic        i_s_axis_tuser,  // [0] opcode
    // Voice command output.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // [6:0] target_key, [13:7] out_velocity, [15:14] zero
    output logic [1:0]  o_m_axis_tuser   // [1:0] command
);

    localparam int unsigned CW = $clog2(MAX_KEYS + 1);

    logic [mnpa_pkg::MODE_W-1:0] r_mode;
    logic [CW-1:0]               r_count;
    logic                        r_busy;
    logic                        r_tok_act;
    mnpa_pkg::t_link             r_tok;
    mnpa_pkg::t_link             n_tok;
    logic                        r_fin_v;
    mnpa_pkg::t_link             r_fin;
    logic                        r_m_valid;
    logic [15:0]                 r_m_data;
    logic [1:0]                  r_m_user;

    mnpa_pkg::t_link             w_link [0:MAX_KEYS];
    mnpa_pkg::t_key              w_key [0:MAX_KEYS-1];
    logic                        low;
    logic                        high;
    logic                        s_acc;
    logic                        out_free;
    logic                        load_out;
    logic [1:0]                  n_cmd;
    mnpa_pkg::t_key              n_tgt;
    logic [mnpa_pkg::VEL_W-1:0]  n_vel;

    assign low = (r_mode == mnpa_pkg::MODE_LOWEST);
    assign high = (r_mode == mnpa_pkg::MODE_HIGHEST);

    assign o_s_axis_tready = !r_busy;
    assign s_acc = i_s_axis_tvalid && !r_busy;
    assign out_free = !r_m_valid || i_m_axis_tready;
    assign load_out = r_fin_v && out_free;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= mnpa_pkg::MODE_LAST;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // Fresh token built from the incoming transaction.
    always_comb begin
        n_tok = '0;
        n_tok.op = i_s_axis_tuser;
        n_tok.key = i_s_axis_tdata[mnpa_pkg::KEY_W-1:0];
        n_tok.vel = i_s_axis_tdata[mnpa_pkg::KEY_W +: mnpa_pkg::VEL_W];
    end

    // Token entering the first cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_act <= 1'b0;
        end else begin
            r_tok_act <= s_acc;
        end
        if (s_acc) begin
            r_tok <= n_tok;
        end
    end

    always_comb begin
        w_link[0] = r_tok;
        w_link[0].active = r_tok_act;
    end

    // Row of key cells.
    for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
        mnpa_pkg::t_key next_key;
        if (g == MAX_KEYS - 1) begin : g_tail
            assign next_key = w_key[g];
        end else begin : g_body
            assign next_key = w_key[g + 1];
        end
        mnpa_cell #(
            .INDEX(g),
            .CW   (CW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_count   (r_count),
            .i_low     (low),
            .i_high    (high),
            .i_link    (w_link[g]),
            .i_next_key(next_key),
            .o_key     (w_key[g]),
            .o_link    (w_link[g + 1])
        );
    end

    // Finished token capture and held count update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_v <= 1'b0;
            r_count <= '0;
            r_busy <= 1'b0;
        end else begin
            if (s_acc) begin
                r_busy <= 1'b1;
            end else if (load_out) begin
                r_busy <= 1'b0;
            end
            if (w_link[MAX_KEYS].active) begin
                r_fin_v <= 1'b1;
                if (w_link[MAX_KEYS].op == mnpa_pkg::OP_PRESS) begin
                    if (w_link[MAX_KEYS].appended) begin
                        r_count <= r_count + CW'(1);
                    end
                end else if (w_link[MAX_KEYS].found) begin
                    r_count <= r_count - CW'(1);
                end
            end else if (load_out) begin
                r_fin_v <= 1'b0;
            end
        end
        if (w_link[MAX_KEYS].active) begin
            r_fin <= w_link[MAX_KEYS];
        end
    end

    // Voice command from the finished token; the count is already updated.
    always_comb begin
        if (r_fin.op == mnpa_pkg::OP_PRESS) begin
            n_cmd = mnpa_pkg::CMD_START;
            n_tgt = (low || high) ? r_fin.best : r_fin.key;
            n_vel = r_fin.vel;
        end else if (r_count != '0) begin
            n_cmd = mnpa_pkg::CMD_RETARGET;
            n_tgt = (low || high) ? r_fin.best : r_fin.last;
            n_vel = '0;
        end else begin
            n_cmd = mnpa_pkg::CMD_STOP;
            n_tgt = r_fin.key;
            n_vel = r_fin.vel;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (load_out) begin
            r_m_data <= {2'b00, n_vel, n_tgt};
            r_m_user <= n_cmd;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata = r_m_data;
    assign o_m_axis_tuser = r_m_user;

endmodule

### rtl/mnpa_cell.sv
// One slot of the held-key list: stores a key and updates the passing token.
module mnpa_cell #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CW = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CW-1:0]       i_count,
    input  logic                i_low,
    input  logic                i_high,
    input  mnpa_pkg::t_link     i_link,
    input  mnpa_pkg::t_key      i_next_key,
    output mnpa_pkg::t_key      o_key,
    output mnpa_pkg::t_link     o_link
);

    mnpa_pkg::t_key  r_key;
    mnpa_pkg::t_link r_link;
    logic            r_act;

    logic            occ;
    logic            occ_next;
    logic            match;
    logic            shift;
    logic            append;
    mnpa_pkg::t_key  cand;
    logic            cand_ok;
    logic            better;
    mnpa_pkg::t_link n_link;

    // Slot occupancy follows from the held count.
    assign occ = i_count > CW'(INDEX);
    assign occ_next = i_count > CW'(INDEX + 1);
    assign match = occ && (r_key == i_link.key);
    // A release shifts every slot from the matching one onward.
    assign shift = (i_link.op == mnpa_pkg::OP_RELEASE) && (i_link.found || match);
    // A press of an absent key lands in the first free slot.
    assign append = (i_link.op == mnpa_pkg::OP_PRESS) && !i_link.found &&
                    (i_count == CW'(INDEX));

    // Candidate value of this slot in the list after the event.
    always_comb begin
        if (i_link.op == mnpa_pkg::OP_PRESS) begin
            cand = append ? i_link.key : r_key;
            cand_ok = append || occ;
        end else begin
            cand = shift ? i_next_key : r_key;
            cand_ok = shift ? occ_next : occ;
        end
    end

    assign better = !i_link.have_best ||
                    (i_low && (cand < i_link.best)) ||
                    (i_high && (cand > i_link.best));

    // Token update for the next cell.
    always_comb begin
        n_link = i_link;
        n_link.found = i_link.found || match;
        n_link.appended = i_link.appended || append;
        if (cand_ok && better) begin
            n_link.have_best = 1'b1;
            n_link.best = cand;
        end
        if (cand_ok) begin
            n_link.have_last = 1'b1;
            n_link.last = cand;
        end
    end

    // Slot storage: written on append or shift only.
    always_ff @(posedge i_clk) begin
        if (i_link.active) begin
            if (append) begin
                r_key <= i_link.key;
            end else if (shift) begin
                r_key <= i_next_key;
            end
        end
    end

    // Token register toward the neighbor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else begin
            r_act <= i_link.active;
        end
        r_link <= n_link;
    end

    assign o_key = r_key;

    always_comb begin
        o_link = r_link;
        o_link.active = r_act;
    end

endmodule
